### sv/srq_pkg.sv
`default_nettype none

package srq_pkg;

	localparam int TempW  = 16;
	localparam int HumiW  = 16;
	localparam int OffW   = 11;
	localparam int LevelW = 3;
	localparam int CountW = 8;
	localparam int GoodTempW = 12;
	localparam int GoodHumiW = 10;
	localparam int IndexW = 3;
	localparam int CfgW   = 11;
	localparam int AmtW   = 5;

	// register indexes on the write port
	localparam logic [IndexW-1:0] REG_TEMP_OFFSET     = 3'd0;
	localparam logic [IndexW-1:0] REG_HUMI_OFFSET     = 3'd1;
	localparam logic [IndexW-1:0] REG_COMP_ENABLE     = 3'd2;
	localparam logic [IndexW-1:0] REG_BACKLIGHT_LEVEL = 3'd3;
	localparam logic [IndexW-1:0] REG_RETRY_LIMIT     = 3'd4;

	localparam logic [LevelW-1:0] BacklightReset = 3'd1;
	localparam logic [CountW-1:0] RetryReset     = 8'd3;
	localparam logic [CountW-1:0] CountMax       = 8'd255;

	localparam logic [AmtW-1:0] CompBase = 5'd20;

	localparam logic signed [TempW-1:0] TempLow  = -16'sd200;
	localparam logic signed [TempW-1:0] TempHigh = 16'sd1500;
	localparam logic signed [HumiW-1:0] HumiHigh = 16'sd1000;

	typedef struct packed {
		logic signed [TempW-1:0] temp;
		logic signed [HumiW-1:0] humi;
	} corr_t;

	// self-heating amount on top of the base, by backlight level
	function automatic logic [AmtW-1:0] comp_amount(input logic [LevelW-1:0] level);
		logic [AmtW-1:0] amt;
		case (level)
			3'd1: amt = 5'd0;
			3'd2: amt = 5'd2;
			3'd3: amt = 5'd5;
			3'd4: amt = 5'd8;
			default: amt = 5'd10;
		endcase
		return amt;
	endfunction

endpackage

`default_nettype wire

### sv/srq_correct.sv
`default_nettype none

module srq_correct (
	input  wire logic signed [srq_pkg::TempW-1:0]  raw_temp,
	input  wire logic signed [srq_pkg::HumiW-1:0]  raw_humi,
	input  wire logic signed [srq_pkg::OffW-1:0]   temp_offset,
	input  wire logic signed [srq_pkg::OffW-1:0]   humi_offset,
	input  wire logic                              comp_enable,
	input  wire logic        [srq_pkg::LevelW-1:0] backlight_level,
	output srq_pkg::corr_t                         corr
);
	import srq_pkg::*;

	logic [AmtW-1:0]         amt;
	logic signed [TempW-1:0] temp_comp;

	assign amt = CompBase + comp_amount(backlight_level);

	// all sums wrap at 16 bits
	always_comb begin
		if (comp_enable) begin
			temp_comp = raw_temp - $signed({{(TempW-AmtW){1'b0}}, amt});
		end else begin
			temp_comp = raw_temp;
		end
		corr.temp = temp_comp + {{(TempW-OffW){temp_offset[OffW-1]}}, temp_offset};
		corr.humi = raw_humi + {{(HumiW-OffW){humi_offset[OffW-1]}}, humi_offset};
	end

endmodule

`default_nettype wire

### sv/srq_judge.sv
`default_nettype none

module srq_judge (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     load,
	input  wire logic                                     read_error,
	input  wire srq_pkg::corr_t                           corr,
	input  wire logic               [srq_pkg::CountW-1:0] retry_limit,
	output logic signed [srq_pkg::GoodTempW-1:0]          good_temp,
	output logic        [srq_pkg::GoodHumiW-1:0]          good_humi,
	output logic                                          temp_fault,
	output logic                                          humi_fault,
	output logic        [srq_pkg::CountW-1:0]             fail_count
);
	import srq_pkg::*;

	logic signed [GoodTempW-1:0] kept_temp_q;
	logic        [GoodHumiW-1:0] kept_humi_q;
	logic        [CountW-1:0]    fail_q;
	logic                        temp_fault_q;
	logic                        humi_fault_q;

	logic              t_ok, h_pos, h_ok, check, t_bad, h_bad;
	logic [CountW-1:0] fail_d;
	logic              temp_fault_d, humi_fault_d;

	always_comb begin
		t_ok  = (corr.temp >= TempLow) && (corr.temp < TempHigh);
		h_pos = corr.humi > 16'sd0;
		h_ok  = h_pos && (corr.humi < HumiHigh);

		// pair test looks at the humidity lower bound only
		if (t_ok && h_pos) begin
			fail_d = '0;
		end else if (fail_q != CountMax) begin
			fail_d = fail_q + 1'b1;
		end else begin
			fail_d = fail_q;
		end

		check = fail_d >= retry_limit;
		// fault bounds leave gaps at the upper limits and at negative humidity
		t_bad = (corr.temp < TempLow) || (corr.temp > TempHigh);
		h_bad = (corr.humi == 16'sd0) || (corr.humi > HumiHigh);

		temp_fault_d = temp_fault_q | read_error;
		if (t_ok) begin
			temp_fault_d = 1'b0;
		end
		if (check && t_bad) begin
			temp_fault_d = 1'b1;
		end

		humi_fault_d = humi_fault_q | read_error;
		if (h_ok) begin
			humi_fault_d = 1'b0;
		end
		if (check && h_bad) begin
			humi_fault_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_temp_q  <= '0;
			kept_humi_q  <= '0;
			fail_q       <= '0;
			temp_fault_q <= 1'b0;
			humi_fault_q <= 1'b0;
		end else if (load) begin
			if (t_ok) begin
				kept_temp_q <= corr.temp[GoodTempW-1:0];
			end
			if (h_ok) begin
				kept_humi_q <= corr.humi[GoodHumiW-1:0];
			end
			fail_q       <= fail_d;
			temp_fault_q <= temp_fault_d;
			humi_fault_q <= humi_fault_d;
		end
	end

	assign good_temp  = kept_temp_q;
	assign good_humi  = kept_humi_q;
	assign temp_fault = temp_fault_q;
	assign humi_fault = humi_fault_q;
	assign fail_count = fail_q;

endmodule

`default_nettype wire

### sv/sensor_reading_qualifier.sv
`default_nettype none

// Qualifies one temperature/humidity reading per transaction. A reading is
// registered on input, corrected (optional self-heating compensation, then
// calibration offsets, wrapping at 16 bits) and judged against the good
// ranges in the next cycle, and the kept values, fault flags and failure count
// after that reading are presented as the result, which sits in the state
// registers themselves, loaded from the input register once the result slot
// is free, so it is shown after both registers; one reading is accepted
// every cycle while results are taken, the limit being the single state update
// per cycle. Configuration registers are written through
// wr_en/wr_index/wr_data and should only change while no reading is in flight.
module sensor_reading_qualifier (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_en,
	input  wire logic        [srq_pkg::IndexW-1:0]    wr_index,
	input  wire logic        [srq_pkg::CfgW-1:0]      wr_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [srq_pkg::TempW-1:0]     raw_temp,
	input  wire logic signed [srq_pkg::HumiW-1:0]     raw_humi,
	input  wire logic                                 read_error,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [srq_pkg::GoodTempW-1:0]      good_temp,
	output logic        [srq_pkg::GoodHumiW-1:0]      good_humi,
	output logic                                      temp_fault,
	output logic                                      humi_fault,
	output logic        [srq_pkg::CountW-1:0]         fail_count
);
	import srq_pkg::*;

	logic signed [OffW-1:0]   temp_offset_q;
	logic signed [OffW-1:0]   humi_offset_q;
	logic                     comp_enable_q;
	logic        [LevelW-1:0] backlight_level_q;
	logic        [CountW-1:0] retry_limit_q;

	logic                    valid_s1;
	logic signed [TempW-1:0] raw_temp_s1;
	logic signed [HumiW-1:0] raw_humi_s1;
	logic                    read_error_s1;

	logic   out_valid_q;
	logic   out_free;
	logic   advance;
	corr_t  corr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_offset_q     <= '0;
			humi_offset_q     <= '0;
			comp_enable_q     <= 1'b0;
			backlight_level_q <= BacklightReset;
			retry_limit_q     <= RetryReset;
		end else if (wr_en) begin
			case (wr_index)
				REG_TEMP_OFFSET:     temp_offset_q     <= wr_data[OffW-1:0];
				REG_HUMI_OFFSET:     humi_offset_q     <= wr_data[OffW-1:0];
				REG_COMP_ENABLE:     comp_enable_q     <= wr_data[0];
				REG_BACKLIGHT_LEVEL: backlight_level_q <= wr_data[LevelW-1:0];
				REG_RETRY_LIMIT:     retry_limit_q     <= wr_data[CountW-1:0];
				default: ;
			endcase
		end
	end

	// result slot is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			raw_temp_s1   <= raw_temp;
			raw_humi_s1   <= raw_humi;
			read_error_s1 <= read_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	srq_correct u_correct (
		.raw_temp        (raw_temp_s1),
		.raw_humi        (raw_humi_s1),
		.temp_offset     (temp_offset_q),
		.humi_offset     (humi_offset_q),
		.comp_enable     (comp_enable_q),
		.backlight_level (backlight_level_q),
		.corr            (corr)
	);

	srq_judge u_judge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance),
		.read_error  (read_error_s1),
		.corr        (corr),
		.retry_limit (retry_limit_q),
		.good_temp   (good_temp),
		.good_humi   (good_humi),
		.temp_fault  (temp_fault),
		.humi_fault  (humi_fault),
		.fail_count  (fail_count)
	);

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
